### rtl/core/trsm_pkg.sv
// Shared types and constants of the touch raw-to-screen mapper.
package trsm_pkg;

  localparam int FIELD_W = 12;
  localparam int X_W = 9;
  localparam int Y_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [FIELD_W-1:0] DEFAULT_THRESHOLD = 12'd350;

  typedef enum logic [2:0] {
    REG_TL_X,
    REG_TL_Y,
    REG_TR_X,
    REG_TR_Y,
    REG_BL_X,
    REG_BL_Y,
    REG_CAL,
    REG_THR
  } reg_idx_t;

  typedef struct packed {
    logic [FIELD_W-1:0] tl_x;
    logic [FIELD_W-1:0] tl_y;
    logic [FIELD_W-1:0] tr_x;
    logic [FIELD_W-1:0] tr_y;
    logic [FIELD_W-1:0] bl_x;
    logic [FIELD_W-1:0] bl_y;
    logic               cal;
    logic [FIELD_W-1:0] thr;
  } calib_t;

  typedef struct packed {
    logic touch_valid;
    logic span_error;
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

### rtl/core/trsm_front.sv
// Front stages: axis swap, numerator and divisor selection, span products.
module trsm_front #(
  parameter int RW     = 12,
  parameter int PW     = 21,
  parameter int SPAN_X = 287,
  parameter int SPAN_Y = 207
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [trsm_pkg::FIELD_W-1:0]  in_raw_x,
  input  logic [trsm_pkg::FIELD_W-1:0]  in_raw_y,
  input  logic [trsm_pkg::FIELD_W-1:0]  in_raw_pressure,
  input  trsm_pkg::calib_t              calib,
  output logic                          out_vld,
  output trsm_pkg::flags_t              out_flags,
  output logic [PW-1:0]                 out_dvd_x,
  output logic [PW-1:0]                 out_dvd_y,
  output logic [RW-1:0]                 out_dvs_x,
  output logic [RW-1:0]                 out_dvs_y
);

  localparam int DW = RW + 1;
  localparam logic [PW-1:0] SPX_V = PW'(SPAN_X);
  localparam logic [PW-1:0] SPY_V = PW'(SPAN_Y);

  logic signed [DW-1:0] rx, ry, tlx, tly, trx, try_v, blx, bly;
  logic signed [DW-1:0] dtx, dty;
  logic [DW-1:0]        adx, ady;
  logic                 swap;
  logic signed [DW-1:0] nx_nxt, ny_nxt, dx_nxt, dy_nxt;
  logic                 err_nxt, tv_nxt;

  logic                 vld1_r;
  logic signed [DW-1:0] nx_r, ny_r, dx_r, dy_r;
  logic                 err1_r, tv1_r;

  logic signed [DW-1:0] anx, any_v, adxv, adyv;
  logic [PW-1:0]        prod_x_nxt, prod_y_nxt;

  logic                 vld2_r;
  trsm_pkg::flags_t     flags2_r;
  logic [PW-1:0]        prod_x_r, prod_y_r;
  logic [RW-1:0]        mdx_r, mdy_r;

  assign rx    = $signed({1'b0, in_raw_x[RW-1:0]});
  assign ry    = $signed({1'b0, in_raw_y[RW-1:0]});
  assign tlx   = $signed({1'b0, calib.tl_x[RW-1:0]});
  assign tly   = $signed({1'b0, calib.tl_y[RW-1:0]});
  assign trx   = $signed({1'b0, calib.tr_x[RW-1:0]});
  assign try_v = $signed({1'b0, calib.tr_y[RW-1:0]});
  assign blx   = $signed({1'b0, calib.bl_x[RW-1:0]});
  assign bly   = $signed({1'b0, calib.bl_y[RW-1:0]});

  assign dtx  = trx - tlx;
  assign dty  = try_v - tly;
  assign adx  = dtx[DW-1] ? DW'(-dtx) : DW'(dtx);
  assign ady  = dty[DW-1] ? DW'(-dty) : DW'(dty);
  assign swap = ady > adx;

  always_comb begin
    if (swap) begin
      nx_nxt = ry - tly;
      dx_nxt = dty;
      ny_nxt = rx - tlx;
      dy_nxt = blx - tlx;
    end else begin
      nx_nxt = rx - tlx;
      dx_nxt = dtx;
      ny_nxt = ry - tly;
      dy_nxt = bly - tly;
    end
    err_nxt = (dx_nxt == '0) || (dy_nxt == '0);
    tv_nxt  = !err_nxt && calib.cal && (in_raw_pressure > calib.thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    err1_r <= err_nxt;
    tv1_r  <= tv_nxt;
  end

  assign anx   = nx_r[DW-1] ? -nx_r : nx_r;
  assign any_v = ny_r[DW-1] ? -ny_r : ny_r;
  assign adxv  = dx_r[DW-1] ? -dx_r : dx_r;
  assign adyv  = dy_r[DW-1] ? -dy_r : dy_r;

  assign prod_x_nxt = PW'(anx[RW-1:0]) * SPX_V;
  assign prod_y_nxt = PW'(any_v[RW-1:0]) * SPY_V;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_x_r             <= prod_x_nxt;
    prod_y_r             <= prod_y_nxt;
    mdx_r                <= adxv[RW-1:0];
    mdy_r                <= adyv[RW-1:0];
    flags2_r.touch_valid <= tv1_r;
    flags2_r.span_error  <= err1_r;
    flags2_r.neg_x       <= nx_r[DW-1] ^ dx_r[DW-1];
    flags2_r.neg_y       <= ny_r[DW-1] ^ dy_r[DW-1];
  end

  assign out_vld   = vld2_r;
  assign out_flags = flags2_r;
  assign out_dvd_x = prod_x_r;
  assign out_dvd_y = prod_y_r;
  assign out_dvs_x = mdx_r;
  assign out_dvs_y = mdy_r;

endmodule

### rtl/core/trsm_div.sv
// Pipelined restoring divider for both axes, one quotient bit per stage.
module trsm_div #(
  parameter int RW = 12,
  parameter int PW = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  trsm_pkg::flags_t in_flags,
  input  logic [PW-1:0]    in_dvd_x,
  input  logic [RW-1:0]    in_dvs_x,
  input  logic [PW-1:0]    in_dvd_y,
  input  logic [RW-1:0]    in_dvs_y,
  output logic             out_vld,
  output trsm_pkg::flags_t out_flags,
  output logic [PW-1:0]    out_quo_x,
  output logic [PW-1:0]    out_quo_y
);

  logic             vld_r   [PW];
  trsm_pkg::flags_t flags_r [PW];
  logic [PW-1:0]    acc_x_r [PW];
  logic [PW-1:0]    acc_y_r [PW];
  logic [RW-1:0]    rem_x_r [PW-1];
  logic [RW-1:0]    rem_y_r [PW-1];
  logic [RW-1:0]    dvs_x_r [PW-1];
  logic [RW-1:0]    dvs_y_r [PW-1];

  for (genvar k = 0; k < PW; k++) begin : g_stage
    logic             vld_i;
    trsm_pkg::flags_t flags_i;
    logic [PW-1:0]    acc_x_i, acc_y_i;
    logic [RW-1:0]    rem_x_i, rem_y_i, dvs_x_i, dvs_y_i;
    logic [RW:0]      trl_x, trl_y, dif_x, dif_y;
    logic             ge_x, ge_y;

    if (k == 0) begin : g_first
      assign vld_i   = in_vld;
      assign flags_i = in_flags;
      assign acc_x_i = in_dvd_x;
      assign acc_y_i = in_dvd_y;
      assign rem_x_i = '0;
      assign rem_y_i = '0;
      assign dvs_x_i = in_dvs_x;
      assign dvs_y_i = in_dvs_y;
    end else begin : g_next
      assign vld_i   = vld_r[k-1];
      assign flags_i = flags_r[k-1];
      assign acc_x_i = acc_x_r[k-1];
      assign acc_y_i = acc_y_r[k-1];
      assign rem_x_i = rem_x_r[k-1];
      assign rem_y_i = rem_y_r[k-1];
      assign dvs_x_i = dvs_x_r[k-1];
      assign dvs_y_i = dvs_y_r[k-1];
    end

    assign trl_x = {rem_x_i, acc_x_i[PW-1]};
    assign trl_y = {rem_y_i, acc_y_i[PW-1]};
    assign dif_x = trl_x - {1'b0, dvs_x_i};
    assign dif_y = trl_y - {1'b0, dvs_y_i};
    assign ge_x  = trl_x >= {1'b0, dvs_x_i};
    assign ge_y  = trl_y >= {1'b0, dvs_y_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      flags_r[k] <= flags_i;
      acc_x_r[k] <= {acc_x_i[PW-2:0], ge_x};
      acc_y_r[k] <= {acc_y_i[PW-2:0], ge_y};
    end

    if (k < PW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_x_r[k] <= ge_x ? dif_x[RW-1:0] : trl_x[RW-1:0];
        rem_y_r[k] <= ge_y ? dif_y[RW-1:0] : trl_y[RW-1:0];
        dvs_x_r[k] <= dvs_x_i;
        dvs_y_r[k] <= dvs_y_i;
      end
    end
  end

  assign out_vld   = vld_r[PW-1];
  assign out_flags = flags_r[PW-1];
  assign out_quo_x = acc_x_r[PW-1];
  assign out_quo_y = acc_y_r[PW-1];

endmodule

### rtl/core/trsm_back.sv
// Back stage: quotient sign, margin offset, screen clamp and result register.
module trsm_back #(
  parameter int PW     = 21,
  parameter int SW     = 320,
  parameter int SH     = 240,
  parameter int MARGIN = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  trsm_pkg::flags_t            in_flags,
  input  logic [PW-1:0]               in_quo_x,
  input  logic [PW-1:0]               in_quo_y,
  output logic                        out_valid,
  output logic                        out_touch_valid,
  output logic [trsm_pkg::X_W-1:0]    out_screen_x,
  output logic [trsm_pkg::Y_W-1:0]    out_screen_y,
  output logic                        out_span_error
);

  localparam int EW = PW + 2;
  localparam logic signed [EW-1:0] MARGIN_V = EW'(MARGIN);
  localparam logic [EW-1:0] SW_V   = EW'(SW);
  localparam logic [EW-1:0] SH_V   = EW'(SH);
  localparam logic [EW-1:0] SWM1_V = EW'(SW - 1);
  localparam logic [EW-1:0] SHM1_V = EW'(SH - 1);

  logic signed [EW-1:0] qx, qy, ex, ey;
  logic [EW-1:0]        cx, cy;

  logic                      valid_r, tv_r, err_r;
  logic [trsm_pkg::X_W-1:0]  sx_r;
  logic [trsm_pkg::Y_W-1:0]  sy_r;

  assign qx = in_flags.neg_x ? -$signed({2'b00, in_quo_x}) : $signed({2'b00, in_quo_x});
  assign qy = in_flags.neg_y ? -$signed({2'b00, in_quo_y}) : $signed({2'b00, in_quo_y});
  assign ex = qx + MARGIN_V;
  assign ey = qy + MARGIN_V;

  always_comb begin
    if (ex[EW-1]) begin
      cx = '0;
    end else if ($unsigned(ex) >= SW_V) begin
      cx = SWM1_V;
    end else begin
      cx = $unsigned(ex);
    end
    if (ey[EW-1]) begin
      cy = '0;
    end else if ($unsigned(ey) >= SH_V) begin
      cy = SHM1_V;
    end else begin
      cy = $unsigned(ey);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    tv_r  <= in_flags.touch_valid;
    err_r <= in_flags.span_error;
    sx_r  <= in_flags.touch_valid ? cx[trsm_pkg::X_W-1:0] : '0;
    sy_r  <= in_flags.touch_valid ? cy[trsm_pkg::Y_W-1:0] : '0;
  end

  assign out_valid       = valid_r;
  assign out_touch_valid = tv_r;
  assign out_screen_x    = sx_r;
  assign out_screen_y    = sy_r;
  assign out_span_error  = err_r;

endmodule

### rtl/core/touch_raw_to_screen_mapper.sv
// Top level of the touch raw-to-screen mapper with its register port.
//
// Maps raw touch samples to screen pixels from three calibration anchors.
// A request is taken on every cycle that start is high; busy stays low.
// Each request yields one result, strobed by out_valid for one cycle.
// The divider takes PW-bit dividends, where PW = min(RAW_BITS, 12) plus
// the bit width of the larger target span, and resolves one quotient bit
// per pipeline stage; two front stages precede it, one output stage follows.
// The receiver must take every result in the cycle it is shown. Registers
// sit at byte address 4*index; the user must write them only while no
// request is in flight, which the block itself does not enforce.
module touch_raw_to_screen_mapper #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  parameter int TARGET_MARGIN = 16,
  parameter int RAW_BITS      = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [trsm_pkg::FIELD_W-1:0]  in_raw_x,
  input  logic [trsm_pkg::FIELD_W-1:0]  in_raw_y,
  input  logic [trsm_pkg::FIELD_W-1:0]  in_raw_pressure,
  output logic                          out_valid,
  output logic                          out_touch_valid,
  output logic [trsm_pkg::X_W-1:0]      out_screen_x,
  output logic [trsm_pkg::Y_W-1:0]      out_screen_y,
  output logic                          out_span_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [trsm_pkg::DATA_W-1:0]   pwdata,
  output logic [trsm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int RW   = (RAW_BITS < trsm_pkg::FIELD_W) ? RAW_BITS : trsm_pkg::FIELD_W;
  localparam int SPX  = SCREEN_WIDTH - 1 - 2 * TARGET_MARGIN;
  localparam int SPY  = SCREEN_HEIGHT - 1 - 2 * TARGET_MARGIN;
  localparam int SPXW = $clog2(SPX + 1);
  localparam int SPYW = $clog2(SPY + 1);
  localparam int SPW  = (SPXW > SPYW) ? SPXW : SPYW;
  localparam int PW   = RW + SPW;
  localparam int LAT  = PW + 3;

  trsm_pkg::calib_t    calib_r;
  trsm_pkg::reg_idx_t  idx;
  logic                wr_en;

  logic                f_vld, d_vld;
  trsm_pkg::flags_t    f_flags, d_flags;
  logic [PW-1:0]       f_dvd_x, f_dvd_y, d_quo_x, d_quo_y;
  logic [RW-1:0]       f_dvs_x, f_dvs_y;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign idx    = trsm_pkg::reg_idx_t'(paddr[trsm_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r.tl_x <= '0;
      calib_r.tl_y <= '0;
      calib_r.tr_x <= '0;
      calib_r.tr_y <= '0;
      calib_r.bl_x <= '0;
      calib_r.bl_y <= '0;
      calib_r.cal  <= 1'b0;
      calib_r.thr  <= trsm_pkg::DEFAULT_THRESHOLD;
    end else if (wr_en) begin
      unique case (idx)
        trsm_pkg::REG_TL_X: calib_r.tl_x <= pwdata[trsm_pkg::FIELD_W-1:0];
        trsm_pkg::REG_TL_Y: calib_r.tl_y <= pwdata[trsm_pkg::FIELD_W-1:0];
        trsm_pkg::REG_TR_X: calib_r.tr_x <= pwdata[trsm_pkg::FIELD_W-1:0];
        trsm_pkg::REG_TR_Y: calib_r.tr_y <= pwdata[trsm_pkg::FIELD_W-1:0];
        trsm_pkg::REG_BL_X: calib_r.bl_x <= pwdata[trsm_pkg::FIELD_W-1:0];
        trsm_pkg::REG_BL_Y: calib_r.bl_y <= pwdata[trsm_pkg::FIELD_W-1:0];
        trsm_pkg::REG_CAL:  calib_r.cal  <= pwdata[0];
        trsm_pkg::REG_THR:  calib_r.thr  <= pwdata[trsm_pkg::FIELD_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      trsm_pkg::REG_TL_X: prdata = trsm_pkg::DATA_W'(calib_r.tl_x);
      trsm_pkg::REG_TL_Y: prdata = trsm_pkg::DATA_W'(calib_r.tl_y);
      trsm_pkg::REG_TR_X: prdata = trsm_pkg::DATA_W'(calib_r.tr_x);
      trsm_pkg::REG_TR_Y: prdata = trsm_pkg::DATA_W'(calib_r.tr_y);
      trsm_pkg::REG_BL_X: prdata = trsm_pkg::DATA_W'(calib_r.bl_x);
      trsm_pkg::REG_BL_Y: prdata = trsm_pkg::DATA_W'(calib_r.bl_y);
      trsm_pkg::REG_CAL:  prdata = trsm_pkg::DATA_W'(calib_r.cal);
      trsm_pkg::REG_THR:  prdata = trsm_pkg::DATA_W'(calib_r.thr);
    endcase
  end

  trsm_front #(
    .RW     (RW),
    .PW     (PW),
    .SPAN_X (SPX),
    .SPAN_Y (SPY)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (start && !busy),
    .in_raw_x        (in_raw_x),
    .in_raw_y        (in_raw_y),
    .in_raw_pressure (in_raw_pressure),
    .calib           (calib_r),
    .out_vld         (f_vld),
    .out_flags       (f_flags),
    .out_dvd_x       (f_dvd_x),
    .out_dvd_y       (f_dvd_y),
    .out_dvs_x       (f_dvs_x),
    .out_dvs_y       (f_dvs_y)
  );

  trsm_div #(
    .RW (RW),
    .PW (PW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (f_vld),
    .in_flags  (f_flags),
    .in_dvd_x  (f_dvd_x),
    .in_dvs_x  (f_dvs_x),
    .in_dvd_y  (f_dvd_y),
    .in_dvs_y  (f_dvs_y),
    .out_vld   (d_vld),
    .out_flags (d_flags),
    .out_quo_x (d_quo_x),
    .out_quo_y (d_quo_y)
  );

  trsm_back #(
    .PW     (PW),
    .SW     (SCREEN_WIDTH),
    .SH     (SCREEN_HEIGHT),
    .MARGIN (TARGET_MARGIN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (d_vld),
    .in_flags        (d_flags),
    .in_quo_x        (d_quo_x),
    .in_quo_y        (d_quo_y),
    .out_valid       (out_valid),
    .out_touch_valid (out_touch_valid),
    .out_screen_x    (out_screen_x),
    .out_screen_y    (out_screen_y),
    .out_span_error  (out_span_error)
  );

  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("request did not yield a result at the pipeline latency");

  a_result_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_touch_valid) |-> (out_screen_x == '0 && out_screen_y == '0))
    else $error("invalid touch carries nonzero coordinates");

  a_err_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span_error) |-> !out_touch_valid)
    else $error("span error reported with a valid touch");

endmodule
